/* rtl/fmsm_pkg.sv */
// shared types, widths and constants of the flow meter session monitor
package fmsm_pkg;

   // payload widths
   localparam int ACTION_W = 2;
   localparam int NOW_W = 32;
   localparam int CH_IN_W = 3;
   localparam int LIMIT_W = 16;
   localparam int STATUS_W = 2;
   localparam int RATE_W = 24;
   localparam int PASS_W = 16;
   localparam int TOTAL_W = 32;

   // internal widths
   localparam int PCNT_W = 16;
   localparam int LEAK_W = 8;
   localparam int PPL_W = 8;
   localparam int ENTRY_W = RATE_W + TOTAL_W;

   // configuration port
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSES_PER_LPM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK_WINDOW_MS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK_PULSE_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKED_TIMEOUT_MS = 2'd3;

   // configuration reset values
   localparam logic [PPL_W-1:0] PPL_RESET = 8'd50;
   localparam logic [NOW_W-1:0] LEAK_WINDOW_RESET = 32'd60000;
   localparam logic [LEAK_W-1:0] LEAK_LIMIT_RESET = 8'd40;
   localparam logic [NOW_W-1:0] BLOCKED_RESET = 32'd4000;

   // rate division: q = (p * 1000000) / (dt * pulses_per_lpm)
   localparam int NUM_W = 36;
   localparam int DIV_W = 40;
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W = 6;
   localparam logic [19:0] ML_SCALE = 20'd1000000;

   // divide by 60 as multiply by ceil(2^30 / 60), exact for q below 2^24
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W = 25;
   localparam int PROD_W = RATE_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_60 = 25'd17895698;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PULSE,
      ACT_COMPUTE,
      ACT_START,
      ACT_STOP
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      FS_STOPPED,
      FS_FLOWING,
      FS_OVERFLOW,
      FS_BLOCKED
   } flow_status_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LEAK_WIN,
      OP_LEAK_CHK,
      OP_START,
      OP_STOP,
      OP_DT,
      OP_MUL,
      OP_DIV,
      OP_SCALE,
      OP_PASS,
      OP_SUM,
      OP_UPDATE
   } dp_op_type;

   typedef struct packed {
      logic      capture;
      logic      load_out;
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_sts_type;

endpackage

/* rtl/fmsm_if.sv */
// request and response channel interfaces

interface fmsm_req_if
   import fmsm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [NOW_W-1:0]    now_ms;
   logic [CH_IN_W-1:0]  channel;
   logic                main_valve_open;
   logic                alert_active;
   logic [LIMIT_W-1:0]  session_limit_ml;

   modport source (
      output valid, action, now_ms, channel, main_valve_open, alert_active,
             session_limit_ml,
      input  ready
   );
   modport sink (
      input  valid, action, now_ms, channel, main_valve_open, alert_active,
             session_limit_ml,
      output ready
   );
endinterface

interface fmsm_rsp_if
   import fmsm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] flow_status;
   logic [RATE_W-1:0]   flow_rate_mlpm;
   logic [PASS_W-1:0]   pass_ml;
   logic [TOTAL_W-1:0]  session_total_ml;
   logic                leak_alert;

   modport source (
      output valid, flow_status, flow_rate_mlpm, pass_ml, session_total_ml, leak_alert,
      input  ready
   );
   modport sink (
      input  valid, flow_status, flow_rate_mlpm, pass_ml, session_total_ml, leak_alert,
      output ready
   );
endinterface

/* rtl/fmsm_ctrl.sv */
// sequencer that steps the datapath through each transaction
module fmsm_ctrl
   import fmsm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   input  dp_sts_type          sts,
   output logic                req_ready,
   output ctrl_cmd_type        cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LEAK_WIN,
      S_LEAK_CHK,
      S_SESSION,
      S_DT,
      S_MUL,
      S_DIV,
      S_SCALE,
      S_PASS,
      S_SUM,
      S_UPDATE,
      S_FINISH
   } state_type;

   state_type         state_ff;
   dp_op_type         op_ff;
   logic              ready_ff;
   logic [STEP_W-1:0] step_cnt_ff;
   logic              fire;

   assign fire = req_valid && ready_ff;

   // command to the datapath
   assign req_ready = ready_ff;
   assign cmd.capture = fire;
   assign cmd.load_out = (state_ff == S_FINISH) && sts.out_free;
   assign cmd.op = op_ff;

   // state, operation and ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_NONE;
         ready_ff <= 1'b1;
         step_cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (fire) begin
                  ready_ff <= 1'b0;
                  unique case (action_type'(req_action))
                     ACT_PULSE: begin
                        state_ff <= S_LEAK_WIN;
                        op_ff <= OP_LEAK_WIN;
                     end
                     ACT_COMPUTE: begin
                        state_ff <= S_DT;
                        op_ff <= OP_DT;
                     end
                     ACT_START: begin
                        state_ff <= S_SESSION;
                        op_ff <= OP_START;
                     end
                     ACT_STOP: begin
                        state_ff <= S_SESSION;
                        op_ff <= OP_STOP;
                     end
                  endcase
               end
            end
            S_LEAK_WIN: begin
               state_ff <= S_LEAK_CHK;
               op_ff <= OP_LEAK_CHK;
            end
            S_LEAK_CHK, S_SESSION, S_UPDATE: begin
               state_ff <= S_FINISH;
               op_ff <= OP_NONE;
            end
            S_DT: begin
               state_ff <= S_MUL;
               op_ff <= OP_MUL;
            end
            S_MUL: begin
               state_ff <= S_DIV;
               op_ff <= OP_DIV;
               step_cnt_ff <= STEP_W'(DIV_STEPS - 1);
            end
            S_DIV: begin
               if (step_cnt_ff == '0) begin
                  state_ff <= S_SCALE;
                  op_ff <= OP_SCALE;
               end else begin
                  step_cnt_ff <= step_cnt_ff - 1'b1;
               end
            end
            S_SCALE: begin
               state_ff <= S_PASS;
               op_ff <= OP_PASS;
            end
            S_PASS: begin
               state_ff <= S_SUM;
               op_ff <= OP_SUM;
            end
            S_SUM: begin
               state_ff <= S_UPDATE;
               op_ff <= OP_UPDATE;
            end
            S_FINISH: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               op_ff <= OP_NONE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

/* rtl/fmsm_dp.sv */
// datapath: counters, leak window, channel store, divider and result register
module fmsm_dp
   import fmsm_pkg::*;
#(
   parameter int unsigned CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [NOW_W-1:0]      req_now_ms,
   input  logic [CH_IN_W-1:0]    req_channel,
   input  logic                  req_main_valve_open,
   input  logic                  req_alert_active,
   input  logic [LIMIT_W-1:0]    req_session_limit_ml,
   input  ctrl_cmd_type          cmd,
   output dp_sts_type            sts,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_flow_status,
   output logic [RATE_W-1:0]     rsp_flow_rate_mlpm,
   output logic [PASS_W-1:0]     rsp_pass_ml,
   output logic [TOTAL_W-1:0]    rsp_session_total_ml,
   output logic                  rsp_leak_alert
);

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration registers
   logic [PPL_W-1:0]   ppl_ff;
   logic [NOW_W-1:0]   leak_window_ff;
   logic [LEAK_W-1:0]  leak_limit_ff;
   logic [NOW_W-1:0]   blocked_timeout_ff;

   // captured transaction
   logic [NOW_W-1:0]   now_ff;
   logic [CW-1:0]      ch_ff;
   logic               valve_ff;
   logic               alert_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // monitor state
   logic [PCNT_W-1:0]  pulse_count_ff;
   logic [LEAK_W-1:0]  leak_count_ff;
   logic [NOW_W-1:0]   win_start_ff;
   logic               win_valid_ff;
   logic [NOW_W-1:0]   pass_start_ff;
   flow_status_type    status_ff;
   logic [CHANNELS-1:0] ent_valid_ff;
   logic [ENTRY_W-1:0] mem [CHANNELS];
   logic [ENTRY_W-1:0] rd_ff;

   // working registers
   logic               leak_arm_ff;
   logic               leak_ff;
   logic [NOW_W-1:0]   dt_ff;
   logic               blocked_ff;
   logic [DIV_W-1:0]   div_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DIV_W-1:0]   rem_ff;
   logic [NUM_W-1:0]   quo_ff;
   logic               sat_ff;
   logic               clr_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [RATE_W-1:0]  res_rate_ff;
   logic [TOTAL_W-1:0] res_total_ff;
   logic [PASS_W-1:0]  pass_ff;
   logic [TOTAL_W:0]   sum_ff;

   // result register
   logic               rsp_valid_ff;
   flow_status_type    out_status_ff;
   logic [RATE_W-1:0]  out_rate_ff;
   logic [PASS_W-1:0]  out_pass_ff;
   logic [TOTAL_W-1:0] out_total_ff;
   logic               out_leak_ff;

   // next values
   logic [CW-1:0]      ch_in;
   logic [NOW_W-1:0]   elapsed;
   logic               win_restart;
   logic [LEAK_W-1:0]  leak_count_in;
   logic [PCNT_W-1:0]  pulse_count_in;
   logic [DIV_W:0]     shifted;
   logic [DIV_W:0]     trial;
   logic               div_zero;
   logic               q_big;
   logic [RATE_W-1:0]  rate_in;
   logic [PASS_W-1:0]  pass_in;
   logic [RATE_W-1:0]  old_rate;
   logic [TOTAL_W-1:0] old_total;
   logic [TOTAL_W-1:0] total_in;
   logic               grew;
   flow_status_type    status_in;

   // channel number folded into range
   always_comb begin
      ch_in = '0;
      for (int v = 0; v < (1 << CH_IN_W); v++) begin
         if (req_channel == CH_IN_W'(v)) begin
            ch_in = CW'(v % CHANNELS);
         end
      end
   end

   // leak window bookkeeping
   always_comb begin
      elapsed = now_ff - win_start_ff;
      win_restart = !win_valid_ff || (elapsed > leak_window_ff);
      if (win_restart) begin
         leak_count_in = LEAK_W'(1);
      end else if (leak_count_ff != '1) begin
         leak_count_in = leak_count_ff + 1'b1;
      end else begin
         leak_count_in = leak_count_ff;
      end
      pulse_count_in = (pulse_count_ff != '1) ? pulse_count_ff + 1'b1 : pulse_count_ff;
   end

   // restoring divider step
   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      trial = shifted - {1'b0, div_ff};
   end

   // rate and pass saturation
   always_comb begin
      div_zero = (div_ff == '0);
      q_big = |quo_ff[NUM_W-1:RATE_W];
      if (div_zero) begin
         rate_in = (pulse_count_ff != '0) ? '1 : '0;
      end else if (q_big) begin
         rate_in = '1;
      end else begin
         rate_in = quo_ff[RATE_W-1:0];
      end
      if (clr_ff) begin
         pass_in = '0;
      end else if (sat_ff || (|prod_ff[PROD_W-1:RECIP_SHIFT+PASS_W])) begin
         pass_in = '1;
      end else begin
         pass_in = prod_ff[RECIP_SHIFT+PASS_W-1:RECIP_SHIFT];
      end
   end

   // stored channel values, empty entries read as zero
   always_comb begin
      old_rate = ent_valid_ff[ch_ff] ? rd_ff[ENTRY_W-1:TOTAL_W] : '0;
      old_total = ent_valid_ff[ch_ff] ? rd_ff[TOTAL_W-1:0] : '0;
   end

   // session total and status
   always_comb begin
      total_in = sum_ff[TOTAL_W] ? '1 : sum_ff[TOTAL_W-1:0];
      grew = (pass_ff != '0) && (old_total != '1);
      if (grew) begin
         status_in = (total_in > TOTAL_W'(limit_ff)) ? FS_OVERFLOW : FS_FLOWING;
      end else begin
         status_in = blocked_ff ? FS_BLOCKED : FS_STOPPED;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ppl_ff <= PPL_RESET;
         leak_window_ff <= LEAK_WINDOW_RESET;
         leak_limit_ff <= LEAK_LIMIT_RESET;
         blocked_timeout_ff <= BLOCKED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PULSES_PER_LPM: ppl_ff <= csr_wdata[PPL_W-1:0];
            CSR_LEAK_WINDOW_MS: leak_window_ff <= csr_wdata[NOW_W-1:0];
            CSR_LEAK_PULSE_LIMIT: leak_limit_ff <= csr_wdata[LEAK_W-1:0];
            CSR_BLOCKED_TIMEOUT_MS: blocked_timeout_ff <= csr_wdata[NOW_W-1:0];
         endcase
      end
   end

   // channel store
   always_ff @(posedge clock) begin
      if (cmd.op == OP_UPDATE) begin
         mem[ch_ff] <= {res_rate_ff, total_in};
      end
      rd_ff <= mem[ch_ff];
   end

   // monitor state and entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff <= '0;
         leak_count_ff <= '0;
         win_start_ff <= '0;
         win_valid_ff <= 1'b0;
         pass_start_ff <= '0;
         status_ff <= FS_STOPPED;
         ent_valid_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_LEAK_WIN: begin
               pulse_count_ff <= pulse_count_in;
               if (!alert_ff && !valve_ff) begin
                  leak_count_ff <= leak_count_in;
                  if (win_restart) begin
                     win_start_ff <= now_ff;
                     win_valid_ff <= 1'b1;
                  end
               end
            end
            OP_START: begin
               status_ff <= FS_STOPPED;
               pass_start_ff <= now_ff;
               ent_valid_ff[ch_ff] <= 1'b0;
            end
            OP_STOP: begin
               status_ff <= FS_STOPPED;
               pass_start_ff <= '0;
               ent_valid_ff <= '0;
            end
            OP_UPDATE: begin
               status_ff <= status_in;
               pulse_count_ff <= '0;
               ent_valid_ff[ch_ff] <= 1'b1;
               if (grew) begin
                  pass_start_ff <= now_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // capture and arithmetic working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff <= req_now_ms;
         ch_ff <= ch_in;
         valve_ff <= req_main_valve_open;
         alert_ff <= req_alert_active;
         limit_ff <= req_session_limit_ml;
         leak_ff <= 1'b0;
         pass_ff <= '0;
      end
      unique case (cmd.op)
         OP_LEAK_WIN: begin
            leak_arm_ff <= !alert_ff && !valve_ff;
         end
         OP_LEAK_CHK: begin
            leak_ff <= leak_arm_ff && (leak_count_ff > leak_limit_ff);
            res_rate_ff <= old_rate;
            res_total_ff <= old_total;
         end
         OP_START, OP_STOP: begin
            res_rate_ff <= '0;
            res_total_ff <= '0;
         end
         OP_DT: begin
            dt_ff <= now_ff - pass_start_ff;
         end
         OP_MUL: begin
            div_ff <= DIV_W'(dt_ff) * DIV_W'(ppl_ff);
            num_ff <= NUM_W'(pulse_count_ff) * NUM_W'(ML_SCALE);
            blocked_ff <= dt_ff > blocked_timeout_ff;
            rem_ff <= '0;
            quo_ff <= '0;
         end
         OP_DIV: begin
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
            if (!trial[DIV_W]) begin
               rem_ff <= trial[DIV_W-1:0];
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[DIV_W-1:0];
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
            end
         end
         OP_SCALE: begin
            res_rate_ff <= rate_in;
            prod_ff <= PROD_W'(quo_ff[RATE_W-1:0]) * PROD_W'(RECIP_60);
            sat_ff <= div_zero ? (pulse_count_ff != '0) : q_big;
            clr_ff <= div_zero && (pulse_count_ff == '0);
         end
         OP_PASS: begin
            pass_ff <= pass_in;
         end
         OP_SUM: begin
            sum_ff <= {1'b0, old_total} + (TOTAL_W + 1)'(pass_ff);
         end
         OP_UPDATE: begin
            res_total_ff <= total_in;
         end
         default: begin
         end
      endcase
   end

   // result register
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff <= status_ff;
         out_rate_ff <= res_rate_ff;
         out_pass_ff <= pass_ff;
         out_total_ff <= res_total_ff;
         out_leak_ff <= leak_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_flow_status = out_status_ff;
   assign rsp_flow_rate_mlpm = out_rate_ff;
   assign rsp_pass_ml = out_pass_ff;
   assign rsp_session_total_ml = out_total_ff;
   assign rsp_leak_alert = out_leak_ff;

endmodule

/* rtl/flow_meter_session_monitor.sv */
// top level of the flow meter session monitor
//
//   channel   direction  handshake          carries
//   req_chan  in         valid/ready        action, now_ms, channel, valve, alert, limit
//   rsp_chan  out        valid/ready        status, rate, pass ml, session total, leak
//   csr_*     in         csr_we, no stall   register index and write data
//
// a compute transaction runs from acceptance to the next acceptance through
// the 36 one-bit steps of the shared restoring divider
// a pulse transaction steps through leak window and leak check, start and stop through the session step
// reset is synchronous; channel entries are cleared at once through per-channel valid bits
// one finished result can wait in the output register while the next transaction runs;
// that transaction then holds in its last step until the output register frees up
module flow_meter_session_monitor
   import fmsm_pkg::*;
#(
   parameter int unsigned CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   fmsm_req_if.sink              req_chan,
   fmsm_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;
   logic         req_ready;
   logic         req_fire;

   assign req_chan.ready = req_ready;
   assign req_fire = req_chan.valid && req_ready;

   // sequencer
   fmsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .sts        (sts),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   // datapath
   fmsm_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_now_ms           (req_chan.now_ms),
      .req_channel          (req_chan.channel),
      .req_main_valve_open  (req_chan.main_valve_open),
      .req_alert_active     (req_chan.alert_active),
      .req_session_limit_ml (req_chan.session_limit_ml),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_flow_status      (rsp_chan.flow_status),
      .rsp_flow_rate_mlpm   (rsp_chan.flow_rate_mlpm),
      .rsp_pass_ml          (rsp_chan.pass_ml),
      .rsp_session_total_ml (rsp_chan.session_total_ml),
      .rsp_leak_alert       (rsp_chan.leak_alert)
   );

   // a result is never loaded in the cycle a new transaction is taken
   a_load_not_with_accept: assert property (
      @(posedge clock) disable iff (reset) cmd.load_out |-> !req_fire
   ) else $error("result load coincides with request acceptance");

   // the result register is only loaded when it is free
   a_load_when_free: assert property (
      @(posedge clock) disable iff (reset)
         cmd.load_out |-> (!rsp_chan.valid || rsp_chan.ready)
   ) else $error("result register overwritten while held");

   // one transaction at a time
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset) req_fire |=> !req_ready
   ) else $error("request accepted while busy");

   // a leak alert only comes from a pulse, which carries no pass volume
   a_leak_has_no_pass: assert property (
      @(posedge clock) disable iff (reset)
         (rsp_chan.valid && rsp_chan.leak_alert) |-> (rsp_chan.pass_ml == '0)
   ) else $error("leak alert reported with pass volume");

endmodule

/* sim/tb_top.sv */
// testbench of the flow meter session monitor: random sessions checked against a predictor
module tb_top;
   import fmsm_pkg::*;

   localparam int CHANNELS = 8;
   localparam int HALF_PERIOD = 4;
   localparam int LIMIT_CYCLES = 800000;
   localparam int SETTLE_CYCLES = 100;
   localparam int SQUEEZE_CYCLES = 600;
   localparam int IDLE_PCT = 24;
   localparam int MAX_REPORTS = 10;
   localparam logic [63:0] MLPM_SCALE = 64'd1000000;
   localparam logic [63:0] SEC_PER_MIN = 64'd60;

   typedef struct packed {
      action_type          act;
      logic [NOW_W-1:0]    now;
      logic [CH_IN_W-1:0]  ch;
      logic                valve;
      logic                alert;
      logic [LIMIT_W-1:0]  limit;
   } meter_req_type;

   typedef struct packed {
      flow_status_type     status;
      logic [RATE_W-1:0]   rate;
      logic [PASS_W-1:0]   pass;
      logic [TOTAL_W-1:0]  total;
      logic                leak;
   } meter_reading_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fmsm_req_if req_bus ();
   fmsm_rsp_if rsp_bus ();

   flow_meter_session_monitor #(.CHANNELS(CHANNELS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // requests waiting to be offered and readings waiting to come back
   meter_req_type meter_requests[$];
   meter_reading_type expected_readings[$];
   meter_req_type offer;
   meter_reading_type want;
   logic offer_open;
   int queued_count;
   int faults;

   // traffic shaping flags set by the sequence
   logic calm;
   logic squeeze_req;
   logic squeeze_done;
   int squeeze_left;

   // predictor copy of the register values
   logic [PPL_W-1:0] cfg_ppl;
   logic [NOW_W-1:0] cfg_window;
   logic [LEAK_W-1:0] cfg_leak_limit;
   logic [NOW_W-1:0] cfg_blocked;

   // predictor copy of the meter state
   logic [PCNT_W-1:0] m_pulses;
   logic [LEAK_W-1:0] m_leak_cnt;
   logic [NOW_W-1:0] m_win_start;
   logic m_win_open;
   logic [NOW_W-1:0] m_pass_t0;
   flow_status_type m_status;
   logic [RATE_W-1:0] chan_rate [CHANNELS];
   logic [TOTAL_W-1:0] chan_total [CHANNELS];

   // clock
   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // reading predicted for one accepted request
   function automatic meter_reading_type predict_reading(meter_req_type rq);
      meter_reading_type rd;
      int idx;
      logic [NOW_W-1:0] dt;
      logic [63:0] divisor;
      logic [63:0] quot;
      logic [63:0] q60;
      logic [63:0] sum;
      logic [TOTAL_W-1:0] old_total;
      rd = '0;
      idx = int'(rq.ch) % CHANNELS;
      case (rq.act)
         ACT_PULSE: begin
            if (m_pulses != '1) m_pulses = m_pulses + 1'b1;
            // closed valve pulses with no alert active count toward the leak window
            if (!rq.alert && !rq.valve) begin
               if (!m_win_open || (rq.now - m_win_start) > cfg_window) begin
                  m_win_start = rq.now;
                  m_win_open = 1'b1;
                  m_leak_cnt = '0;
               end
               if (m_leak_cnt != '1) m_leak_cnt = m_leak_cnt + 1'b1;
               rd.leak = (m_leak_cnt > cfg_leak_limit);
            end
         end
         ACT_COMPUTE: begin
            dt = rq.now - m_pass_t0;
            divisor = {32'd0, dt} * {56'd0, cfg_ppl};
            // zero divisor saturates when anything was counted
            if (divisor == 64'd0) quot = (m_pulses != '0) ? '1 : '0;
            else quot = (MLPM_SCALE * {48'd0, m_pulses}) / divisor;
            chan_rate[idx] = (quot > 64'hFF_FFFF) ? '1 : quot[RATE_W-1:0];
            q60 = quot / SEC_PER_MIN;
            rd.pass = (q60 > 64'hFFFF) ? '1 : q60[PASS_W-1:0];
            old_total = chan_total[idx];
            sum = {32'd0, old_total} + {48'd0, rd.pass};
            chan_total[idx] = (sum > 64'hFFFF_FFFF) ? '1 : sum[TOTAL_W-1:0];
            // classify by whether the session total moved
            if (chan_total[idx] > old_total) begin
               m_status = (chan_total[idx] > {16'd0, rq.limit}) ? FS_OVERFLOW : FS_FLOWING;
               m_pass_t0 = rq.now;
            end else begin
               m_status = (dt > cfg_blocked) ? FS_BLOCKED : FS_STOPPED;
            end
            m_pulses = '0;
         end
         ACT_START: begin
            m_status = FS_STOPPED;
            chan_rate[idx] = '0;
            chan_total[idx] = '0;
            m_pass_t0 = rq.now;
         end
         default: begin
            m_status = FS_STOPPED;
            m_pass_t0 = '0;
            for (int k = 0; k < CHANNELS; k++) begin
               chan_rate[k] = '0;
               chan_total[k] = '0;
            end
         end
      endcase
      rd.status = m_status;
      rd.rate = chan_rate[idx];
      rd.total = chan_total[idx];
      return rd;
   endfunction

   function automatic void report_fault(string msg);
      faults++;
      if (faults <= MAX_REPORTS) $display("%s", msg);
   endfunction

   // request driver: offers change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!offer_open) begin
         if (meter_requests.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            offer = meter_requests.pop_front();
            offer_open = 1'b1;
            req_bus.valid <= 1'b1;
            req_bus.action <= offer.act;
            req_bus.now_ms <= offer.now;
            req_bus.channel <= offer.ch;
            req_bus.main_valve_open <= offer.valve;
            req_bus.alert_active <= offer.alert;
            req_bus.session_limit_ml <= offer.limit;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // request acceptance and prediction
   always @(posedge clock) begin
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         expected_readings.push_back(predict_reading(offer));
         offer_open = 1'b0;
      end
   end

   // response receiver with random stalls and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (squeeze_req && !squeeze_done) begin
            squeeze_left = SQUEEZE_CYCLES;
            squeeze_done = 1'b1;
         end
         if (squeeze_left > 0) begin
            squeeze_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_readings.size() == 0) begin
            report_fault($sformatf({"unexpected reading: status %0d rate %0d pass %0d",
               " total %0d leak %0b"},
               rsp_bus.flow_status, rsp_bus.flow_rate_mlpm, rsp_bus.pass_ml,
               rsp_bus.session_total_ml, rsp_bus.leak_alert));
         end else begin
            want = expected_readings.pop_front();
            if (rsp_bus.flow_status !== want.status || rsp_bus.flow_rate_mlpm !== want.rate
                || rsp_bus.pass_ml !== want.pass || rsp_bus.session_total_ml !== want.total
                || rsp_bus.leak_alert !== want.leak) begin
               report_fault($sformatf({"reading mismatch: status %0d/%0d rate %0d/%0d pass %0d/%0d",
                  " total %0d/%0d leak %0b/%0b (expected/actual)"},
                  want.status, rsp_bus.flow_status, want.rate, rsp_bus.flow_rate_mlpm,
                  want.pass, rsp_bus.pass_ml, want.total, rsp_bus.session_total_ml,
                  want.leak, rsp_bus.leak_alert));
            end
         end
      end
   end

   task automatic queue_item(input action_type act, input logic [NOW_W-1:0] now,
                             input logic [CH_IN_W-1:0] ch, input logic valve,
                             input logic alert, input logic [LIMIT_W-1:0] limit);
      meter_req_type rq;
      rq.act = act;
      rq.now = now;
      rq.ch = ch;
      rq.valve = valve;
      rq.alert = alert;
      rq.limit = limit;
      meter_requests.push_back(rq);
      queued_count++;
   endtask

   // one session: start, then passes of pulses each closed by a compute
   task automatic queue_session();
      logic [NOW_W-1:0] t;
      logic [NOW_W-1:0] t0;
      logic [CH_IN_W-1:0] ch;
      logic [LIMIT_W-1:0] lim;
      int hits;
      case ($urandom_range(0, 2))
         0: t = $urandom;
         1: t = 32'hFFFF_FFFF - $urandom_range(0, 4000);
         default: t = $urandom_range(0, 100000);
      endcase
      ch = CH_IN_W'($urandom_range(0, CHANNELS - 1));
      case ($urandom_range(0, 3))
         0: lim = LIMIT_W'($urandom_range(0, 40));
         1: lim = '1;
         default: lim = LIMIT_W'($urandom);
      endcase
      queue_item(ACT_START, t, ch, 1'b1, 1'($urandom_range(0, 1)), lim);
      t0 = t;
      repeat ($urandom_range(1, 5)) begin
         hits = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
         repeat (hits) begin
            t = t + $urandom_range(0, 60);
            queue_item(ACT_PULSE, t, ($urandom_range(0, 9) == 0) ? CH_IN_W'($urandom) : ch,
                       $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0, lim);
         end
         // elapsed time: none, very short, three to nine seconds or about a second
         case ($urandom_range(0, 5))
            0: t = t0;
            1: t = t + $urandom_range(0, 20);
            2: t = t + $urandom_range(3000, 9000);
            default: t = t + $urandom_range(200, 1500);
         endcase
         queue_item(ACT_COMPUTE, t, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    lim);
         t0 = t;
      end
   endtask

   // closed valve pulses spread over the leak window
   task automatic queue_leak_burst(input int count, input int max_gap);
      logic [NOW_W-1:0] t;
      t = $urandom;
      repeat (count) begin
         t = t + $urandom_range(0, max_gap);
         queue_item(ACT_PULSE, t, CH_IN_W'($urandom), 1'b0, $urandom_range(0, 7) == 0,
                    LIMIT_W'($urandom));
      end
   endtask

   task automatic queue_random_phase(input int count);
      int goal;
      goal = queued_count + count;
      while (queued_count < goal) begin
         case ($urandom_range(0, 9))
            0, 1: queue_leak_burst($urandom_range(5, 50), 400);
            2: begin
               repeat ($urandom_range(1, 4))
                  queue_item(action_type'(ACTION_W'($urandom_range(0, 3))), $urandom,
                             CH_IN_W'($urandom), 1'($urandom), 1'($urandom),
                             LIMIT_W'($urandom));
            end
            3: queue_item(ACT_STOP, $urandom, CH_IN_W'($urandom), 1'($urandom), 1'($urandom),
                          LIMIT_W'($urandom));
            default: queue_session();
         endcase
      end
   endtask

   task automatic wait_drained();
      while (meter_requests.size() != 0 || offer_open || expected_readings.size() != 0)
         @(negedge clock);
   endtask

   // register writes, issued only while nothing is in flight
   task automatic load_settings(input logic [PPL_W-1:0] ppl, input logic [NOW_W-1:0] window,
                                input logic [LEAK_W-1:0] leak_limit,
                                input logic [NOW_W-1:0] blocked);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_PULSES_PER_LPM;
      csr_wdata <= {24'd0, ppl};
      @(negedge clock);
      csr_index <= CSR_LEAK_WINDOW_MS;
      csr_wdata <= window;
      @(negedge clock);
      csr_index <= CSR_LEAK_PULSE_LIMIT;
      csr_wdata <= {24'd0, leak_limit};
      @(negedge clock);
      csr_index <= CSR_BLOCKED_TIMEOUT_MS;
      csr_wdata <= blocked;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_ppl = ppl;
      cfg_window = window;
      cfg_leak_limit = leak_limit;
      cfg_blocked = blocked;
   endtask

   // run limit
   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("== FAIL ==");
      $finish;
   end

   // sequence
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_PULSES_PER_LPM;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_PULSE;
      req_bus.now_ms = '0;
      req_bus.channel = '0;
      req_bus.main_valve_open = 1'b0;
      req_bus.alert_active = 1'b0;
      req_bus.session_limit_ml = '0;
      rsp_bus.ready = 1'b0;
      offer_open = 1'b0;
      queued_count = 0;
      faults = 0;
      calm = 1'b0;
      squeeze_req = 1'b0;
      squeeze_done = 1'b0;
      squeeze_left = 0;
      cfg_ppl = PPL_RESET;
      cfg_window = LEAK_WINDOW_RESET;
      cfg_leak_limit = LEAK_LIMIT_RESET;
      cfg_blocked = BLOCKED_RESET;
      m_pulses = '0;
      m_leak_cnt = '0;
      m_win_start = '0;
      m_win_open = 1'b0;
      m_pass_t0 = '0;
      m_status = FS_STOPPED;
      for (int k = 0; k < CHANNELS; k++) begin
         chan_rate[k] = '0;
         chan_total[k] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed cases under reset register values
      // zero elapsed time, first without and then with a counted pulse
      queue_item(ACT_COMPUTE, 32'd0, 3'd0, 1'b1, 1'b0, 16'd0);
      queue_item(ACT_PULSE, 32'd0, 3'd0, 1'b1, 1'b0, 16'd0);
      queue_item(ACT_COMPUTE, 32'd0, 3'd0, 1'b1, 1'b0, 16'd0);
      // session across the time wrap, then two blocked passes
      queue_item(ACT_START, 32'hFFFF_FF00, 3'd7, 1'b1, 1'b1, 16'hFFFF);
      for (int k = 0; k < 5; k++)
         queue_item(ACT_PULSE, 32'hFFFF_FF10 + 32'(k * 16), 3'd7, 1'b1, 1'b1, 16'hFFFF);
      queue_item(ACT_COMPUTE, 32'h0000_0100, 3'd7, 1'b1, 1'b1, 16'hFFFF);
      queue_item(ACT_COMPUTE, 32'h0000_2000, 3'd7, 1'b1, 1'b1, 16'hFFFF);
      queue_item(ACT_COMPUTE, 32'h0000_2100, 3'd7, 1'b1, 1'b1, 16'hFFFF);
      // leak window: alert active ignored, open, wrap, then restart
      queue_item(ACT_PULSE, 32'h0000_2200, 3'd2, 1'b0, 1'b1, 16'd0);
      queue_item(ACT_PULSE, 32'hFFFF_FFFF, 3'd2, 1'b0, 1'b0, 16'd0);
      queue_item(ACT_PULSE, 32'd0, 3'd2, 1'b0, 1'b0, 16'd0);
      queue_item(ACT_PULSE, 32'd60001, 3'd2, 1'b0, 1'b0, 16'd0);
      // stop clears every channel, long elapsed time reads as blocked
      queue_item(ACT_STOP, 32'd12345, 3'd3, 1'b1, 1'b0, 16'd0);
      queue_item(ACT_COMPUTE, 32'hFFFF_FFFF, 3'd3, 1'b1, 1'b0, 16'd0);
      // short pass over the session limit, then an empty one
      queue_item(ACT_START, 32'd1000, 3'd5, 1'b1, 1'b0, 16'd300);
      queue_item(ACT_PULSE, 32'd1000, 3'd5, 1'b1, 1'b0, 16'd300);
      queue_item(ACT_COMPUTE, 32'd1001, 3'd5, 1'b1, 1'b0, 16'd300);
      queue_item(ACT_COMPUTE, 32'd1001, 3'd5, 1'b1, 1'b0, 16'd300);
      wait_drained();

      // upper extremes of every register
      load_settings(8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_random_phase(120);
      wait_drained();

      // lower extremes, no idling on either side
      load_settings(8'd1, 32'd1, 8'd0, 32'd0);
      calm = 1'b1;
      queue_random_phase(120);
      wait_drained();
      calm = 1'b0;

      // zero calibration divides by zero on every compute
      load_settings(8'd0, 32'd200, 8'd2, 32'd1500);
      queue_random_phase(120);
      wait_drained();

      // a long burst of pulses drives the leak counter toward its ceiling
      load_settings(8'd50, 32'hFFFF_FFFF, 8'd254, 32'd4000);
      queue_leak_burst(260, 1000);
      queue_item(ACT_COMPUTE, $urandom, CH_IN_W'($urandom), 1'b1, 1'b0, LIMIT_W'($urandom));
      wait_drained();

      // random register values, the first with a long receiver hold-off
      for (int ph = 0; ph < 4; ph++) begin
         load_settings(PPL_W'($urandom_range(1, 255)), $urandom_range(20, 5000),
                       LEAK_W'($urandom_range(0, 8)), $urandom_range(500, 6000));
         if (ph == 0) squeeze_req = 1'b1;
         queue_random_phase(120);
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_readings.size() != 0)
         report_fault($sformatf("%0d readings never arrived", expected_readings.size()));
      if (faults == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
